FILE: hdl/chkv_pkg.sv
package chkv_pkg;

  localparam int unsigned BucketsDefault = 256;
  localparam int unsigned EntriesDefault = 192;

  localparam logic [63:0] Mix1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] Mix2 = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [2:0] {
    FuncSet    = 3'd0,
    FuncGet    = 3'd1,
    FuncHas    = 3'd2,
    FuncDel    = 3'd3,
    FuncInval  = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    StatusOk     = 2'd0,
    StatusAbsent = 2'd1,
    StatusNull   = 2'd2,
    StatusFull   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    StIdle,
    StMix1,
    StMix2,
    StMix3,
    StHeadRd,
    StHeadWait,
    StEntWait,
    StEntChk,
    StPopWait,
    StAct,
    StOut,
    StClear
  } state_e;

endpackage

FILE: hdl/chained_hash_key_value_table.sv
// Maps 64-bit keys to 64-bit values through a murmur3-finalizer hash onto BUCKETS chained
// buckets backed by a pool of ENTRIES slots; the hash is masked, so BUCKETS must be a power
// of two, which the block itself does not enforce. One item is taken at a time, and none
// while a result waits in the one-deep output register. Each item runs through two 64-bit
// hash products of three 32-bit partial products each, a final mix step, a head read, then
// one read per chain entry visited over the shared entry memory port, before its result is
// registered. The next item is taken once the result has been taken and the output
// register has emptied. After reset a clearing pass over the larger of BUCKETS and ENTRIES
// addresses empties the bucket-head memory and loads the free-slot stack, and no item is
// taken during it. Key zero and unused func codes return status 2 in the cycle after the
// item is taken; a set of a new key with the pool full returns 3.
module chained_hash_key_value_table
  import chkv_pkg::*;
#(
  parameter int unsigned BUCKETS = BucketsDefault,
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [2:0]  func_i,
  input  logic [63:0] key_i,
  input  logic [63:0] value_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [1:0]  status_o,
  output logic        present_o,
  output logic [63:0] out_value_o,
  output logic        retain_out_o,
  output logic        retain_input_o,
  output logic [63:0] release_value_o,
  output logic        release_valid_o,
  output logic        register_key_o,
  output logic        deregister_key_o
);

  localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned SW = (BUCKETS > ENTRIES) ? BW : EW;
  localparam logic [CW-1:0] EntCnt = CW'(ENTRIES);
  localparam logic [SW-1:0] LastS = SW'(BUCKETS > ENTRIES ? BUCKETS - 1 : ENTRIES - 1);

  // head memory: valid bit plus slot
  logic [EW:0]   head_mem [BUCKETS];
  logic [63:0]   key_mem  [ENTRIES];
  logic [63:0]   val_mem  [ENTRIES];
  logic [EW:0]   link_mem [ENTRIES];
  logic [EW-1:0] free_mem [ENTRIES];

  state_e        state_q, state_d;
  logic [2:0]    func_q;
  logic [63:0]   key_q, value_q, h_q, h_d;
  logic [BW-1:0] bkt_q;
  logic [EW:0]   cur_q, cur_d;      // msb valid
  logic          has_prev_q, has_prev_d;
  logic [EW-1:0] prev_q, prev_d;
  logic [CW-1:0] live_q, live_d, steps_q, steps_d;
  logic [SW-1:0] clr_q;
  logic [EW:0]   head_rd_q, link_rd_q;
  logic [63:0]   key_rd_q, val_rd_q;
  logic [EW-1:0] free_rd_q;
  logic [1:0]    mph_q, mph_d;
  logic [63:0]   acc_q, acc_d;

  logic          out_v_q;
  logic [1:0]    status_q;
  logic          present_q, retain_out_q, retain_in_q, rel_v_q, reg_q, dereg_q;
  logic [63:0]   out_val_q, rel_val_q;

  // memory control
  logic          head_we, ent_we, val_we, link_we, free_we;
  logic [BW-1:0] head_wa;
  logic [EW:0]   head_wd, link_wd;
  logic [EW-1:0] ent_wa, link_wa, free_wa, ent_ra, free_ra;
  logic [EW-1:0] top_idx, free_slot;
  logic          load_out;
  logic [1:0]    st_d;
  logic          pres_d, rout_d, rin_d, relv_d, reg_d, dreg_d;
  logic [63:0]   oval_d, rval_d;

  logic [63:0] xs;
  assign xs = h_q ^ (h_q >> 33);

  // one 32x32 partial product per cycle
  logic [63:0] mul_k;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] mul_hi;
  assign mul_k = (state_q == StMix1) ? Mix1 : Mix2;
  assign mul_a = (mph_q == 2'd2) ? xs[63:32] : xs[31:0];
  assign mul_b = (mph_q == 2'd1) ? mul_k[63:32] : mul_k[31:0];
  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign mul_hi = acc_q[63:32] + mul_p[31:0];

  assign stall_o = (state_q != StIdle) || out_v_q;
  assign top_idx = EW'(EntCnt - CW'(1) - live_q);
  assign free_slot = (32'(free_rd_q) >= ENTRIES) ? EW'(32'(free_rd_q) - ENTRIES) : free_rd_q;

  always_comb begin
    state_d = state_q;
    h_d = h_q;
    acc_d = acc_q;
    mph_d = mph_q;
    cur_d = cur_q;
    has_prev_d = has_prev_q;
    prev_d = prev_q;
    live_d = live_q;
    steps_d = steps_q;
    head_we = 1'b0; head_wa = bkt_q; head_wd = '0;
    ent_we = 1'b0; val_we = 1'b0; ent_wa = cur_q[EW-1:0];
    link_we = 1'b0; link_wa = prev_q; link_wd = '0;
    free_we = 1'b0; free_wa = top_idx;
    ent_ra = cur_q[EW-1:0];
    free_ra = top_idx;
    load_out = 1'b0;
    st_d = StatusOk;
    pres_d = 1'b0; rout_d = 1'b0; rin_d = 1'b0; relv_d = 1'b0;
    reg_d = 1'b0; dreg_d = 1'b0;
    oval_d = '0; rval_d = '0;
    unique case (state_q)
      StClear: begin
        head_we = 1'b1;
        head_wa = BW'(clr_q);
        free_we = 32'(clr_q) < ENTRIES;
        free_wa = EW'(clr_q);
        if (clr_q == LastS) state_d = StIdle;
      end
      StIdle: begin
        if (valid_i && !stall_o) begin
          if (key_i == '0 || func_i > FuncInval) begin
            load_out = 1'b1;
            st_d = StatusNull;
          end else begin
            h_d = key_i;
            state_d = StMix1;
          end
        end
      end
      StMix1, StMix2: begin
        if (mph_q == 2'd0) begin
          acc_d = mul_p;
          mph_d = 2'd1;
        end else if (mph_q == 2'd1) begin
          acc_d = {mul_hi, acc_q[31:0]};
          mph_d = 2'd2;
        end else begin
          h_d = {mul_hi, acc_q[31:0]};
          mph_d = 2'd0;
          state_d = (state_q == StMix1) ? StMix2 : StMix3;
        end
      end
      StMix3: begin
        h_d = xs;
        state_d = StHeadRd;
      end
      StHeadRd: state_d = StHeadWait;
      StHeadWait: begin
        cur_d = head_rd_q;
        has_prev_d = 1'b0;
        prev_d = '0;
        steps_d = '0;
        state_d = StEntWait;
      end
      StEntWait: begin
        if (!cur_q[EW] || 32'(cur_q[EW-1:0]) >= ENTRIES || steps_q >= EntCnt) begin
          state_d = StPopWait;
          cur_d[EW] = 1'b0;
        end else begin
          state_d = StEntChk;
        end
      end
      StEntChk: begin
        if (key_rd_q == key_q) begin
          state_d = StAct;
        end else begin
          has_prev_d = 1'b1;
          prev_d = cur_q[EW-1:0];
          cur_d = link_rd_q;
          steps_d = steps_q + 1'b1;
          state_d = StEntWait;
        end
      end
      StPopWait: begin
        state_d = StOut;
        load_out = 1'b1;
        if (func_q != FuncSet) begin
          st_d = StatusAbsent;
        end else if (live_q >= EntCnt) begin
          st_d = StatusFull;
        end else begin
          state_d = StIdle;
          ent_we = 1'b1; val_we = 1'b1; ent_wa = free_slot;
          head_we = 1'b1; head_wd = {1'b1, free_slot};
          link_we = 1'b1; link_wa = free_slot; link_wd = head_rd_q;
          live_d = live_q + 1'b1;
          rin_d = value_q != '0;
          reg_d = 1'b1;
        end
        if (state_d == StOut) state_d = StIdle;
      end
      StAct: begin
        state_d = StIdle;
        load_out = 1'b1;
        pres_d = 1'b1;
        unique case (func_q)
          FuncSet: begin
            val_we = 1'b1;
            rin_d = value_q != '0;
            rval_d = val_rd_q;
            relv_d = val_rd_q != '0;
          end
          FuncGet: begin
            oval_d = val_rd_q;
            rout_d = val_rd_q != '0;
          end
          FuncDel, FuncInval: begin
            if (has_prev_q) begin
              link_we = 1'b1;
              link_wd = link_rd_q;
            end else begin
              head_we = 1'b1;
              head_wd = link_rd_q;
            end
            if (live_q > '0) begin
              live_d = live_q - 1'b1;
              free_we = 1'b1;
              free_wa = EW'(EntCnt - CW'(1) - live_d);
            end
            rval_d = val_rd_q;
            relv_d = val_rd_q != '0;
            dreg_d = func_q == FuncDel;
          end
          default: ;
        endcase
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd_q <= head_mem[bkt_q];
    if (ent_we) key_mem[ent_wa] <= key_q;
    if (val_we) val_mem[ent_wa] <= value_q;
    key_rd_q <= key_mem[ent_ra];
    val_rd_q <= val_mem[ent_ra];
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_q <= link_mem[ent_ra];
    if (free_we) free_mem[free_wa] <= (state_q == StClear) ? EW'(clr_q) : cur_q[EW-1:0];
    free_rd_q <= free_mem[free_ra];
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    acc_q <= acc_d;
    cur_q <= cur_d;
    prev_q <= prev_d;
    has_prev_q <= has_prev_d;
    steps_q <= steps_d;
    if (state_q == StMix3) bkt_q <= xs[BW-1:0];
    if (state_q == StIdle && valid_i && !stall_o) begin
      func_q <= func_i;
      key_q <= key_i;
      value_q <= value_i;
    end
    if (load_out) begin
      status_q <= st_d;
      present_q <= pres_d;
      out_val_q <= oval_d;
      retain_out_q <= rout_d;
      retain_in_q <= rin_d;
      rel_val_q <= rval_d;
      rel_v_q <= relv_d;
      reg_q <= reg_d;
      dereg_q <= dreg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      live_q <= '0;
      mph_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q <= live_d;
      mph_q <= mph_d;
      if (state_q == StClear) clr_q <= clr_q + 1'b1;
      if (load_out) out_v_q <= 1'b1;
      else if (!stall_i) out_v_q <= 1'b0;
    end
  end

  assign valid_o = out_v_q;
  assign status_o = status_q;
  assign present_o = present_q;
  assign out_value_o = out_val_q;
  assign retain_out_o = retain_out_q;
  assign retain_input_o = retain_in_q;
  assign release_value_o = rel_val_q;
  assign release_valid_o = rel_v_q;
  assign register_key_o = reg_q;
  assign deregister_key_o = dereg_q;

endmodule

FILE: hdl/chkv_checker.sv
module chkv_checker
  import chkv_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [1:0]  status_o,
  input logic        present_o,
  input logic [63:0] out_value_o,
  input logic        retain_out_o,
  input logic        register_key_o,
  input logic        deregister_key_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(out_value_o) && $stable(status_o))
    else $error("stalled item changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o)
    else $error("input taken while item pending");

  a_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && register_key_o |-> !present_o && status_o == StatusOk)
    else $error("register on present key");

  a_get: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && retain_out_o |-> present_o && out_value_o != '0 && !deregister_key_o)
    else $error("retain without value");

endmodule

bind chained_hash_key_value_table chkv_checker u_chkv_checker (.*);

FILE: tb/tb.sv
module tb;
  import chkv_pkg::*;

  localparam int unsigned NumBuckets = BucketsDefault;
  localparam int unsigned NumEntries = EntriesDefault;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned KeyPoolSize = 300;

  typedef struct packed {
    status_e     status;
    logic        present;
    logic [63:0] out_value;
    logic        retain_out;
    logic        retain_input;
    logic [63:0] release_value;
    logic        release_valid;
    logic        register_key;
    logic        deregister_key;
  } table_result_t;

  class table_scoreboard;
    logic [7:0]    head_slot[NumBuckets];
    bit            head_ok[NumBuckets];
    logic [63:0]   slot_key[NumEntries];
    logic [63:0]   slot_value[NumEntries];
    logic [7:0]    slot_next[NumEntries];
    bit            next_ok[NumEntries];
    logic [7:0]    free_stack[NumEntries];
    int unsigned   live;
    table_result_t awaited[$];
    int unsigned   mismatches;

    function new();
      for (int i = 0; i < NumBuckets; i++) head_ok[i] = 0;
      for (int i = 0; i < NumEntries; i++) begin
        free_stack[i] = 8'(i);
        next_ok[i] = 0;
      end
      live = 0;
      mismatches = 0;
    endfunction

    function logic [7:0] bucket_hash(logic [63:0] k);
      k = k ^ (k >> 33);
      k = k * Mix1;
      k = k ^ (k >> 33);
      k = k * Mix2;
      k = k ^ (k >> 33);
      return 8'(k % NumBuckets);
    endfunction

    function void note_item(logic [2:0] func, logic [63:0] key, logic [63:0] value);
      table_result_t r;
      logic [7:0] b;
      logic [7:0] cur;
      logic [7:0] slot;
      logic [7:0] prev;
      logic [7:0] s;
      bit v;
      bit has_prev;
      bit found;
      int unsigned steps;
      logic [63:0] old;
      r = '0;
      r.status = StatusOk;
      if (key == 0 || func > 3'd4) begin
        r.status = StatusNull;
        awaited.push_back(r);
        return;
      end
      b = bucket_hash(key);
      v = head_ok[b];
      cur = head_slot[b];
      steps = 0;
      has_prev = 0;
      prev = 0;
      found = 0;
      slot = 0;
      while (v && cur < NumEntries && steps < NumEntries && !found) begin
        if (slot_key[cur] == key) begin
          slot = cur;
          found = 1;
        end else begin
          has_prev = 1;
          prev = cur;
          v = next_ok[cur];
          cur = slot_next[cur];
          steps++;
        end
      end
      if (!found) begin
        if (func != FuncSet) r.status = StatusAbsent;
        else if (live >= NumEntries) r.status = StatusFull;
        else begin
          s = 8'(free_stack[NumEntries - 1 - live] % NumEntries);
          slot_key[s] = key;
          slot_value[s] = value;
          slot_next[s] = head_slot[b];
          next_ok[s] = head_ok[b];
          head_slot[b] = s;
          head_ok[b] = 1;
          live++;
          r.retain_input = value != 0;
          r.register_key = 1;
        end
        awaited.push_back(r);
        return;
      end
      r.present = 1;
      old = slot_value[slot];
      case (func)
        FuncSet: begin
          slot_value[slot] = value;
          r.retain_input = value != 0;
          r.release_value = old;
          r.release_valid = old != 0;
        end
        FuncGet: begin
          r.out_value = old;
          r.retain_out = old != 0;
        end
        FuncDel, FuncInval: begin
          if (has_prev) begin
            slot_next[prev] = slot_next[slot];
            next_ok[prev] = next_ok[slot];
          end else begin
            head_slot[b] = slot_next[slot];
            head_ok[b] = next_ok[slot];
          end
          if (live > 0) begin
            live--;
            free_stack[NumEntries - 1 - live] = slot;
          end
          r.release_value = old;
          r.release_valid = old != 0;
          r.deregister_key = func == FuncDel;
        end
        default: ;
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(table_result_t got);
      table_result_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = awaited.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: expected st=%0d pr=%0b ov=%h ro=%0b ri=%0b rv=%h rl=%0b rg=%0b dr=%0b",
                   want.status, want.present, want.out_value, want.retain_out,
                   want.retain_input, want.release_value, want.release_valid,
                   want.register_key, want.deregister_key);
          $display("          actual   st=%0d pr=%0b ov=%h ro=%0b ri=%0b rv=%h rl=%0b rg=%0b dr=%0b",
                   got.status, got.present, got.out_value, got.retain_out,
                   got.retain_input, got.release_value, got.release_valid,
                   got.register_key, got.deregister_key);
        end
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        valid_i = 0;
  logic        stall_o;
  logic [2:0]  func_i = '0;
  logic [63:0] key_i = '0;
  logic [63:0] value_i = '0;
  logic        valid_o;
  logic        stall_i = 0;
  logic [1:0]  status_o;
  logic        present_o;
  logic [63:0] out_value_o;
  logic        retain_out_o;
  logic        retain_input_o;
  logic [63:0] release_value_o;
  logic        release_valid_o;
  logic        register_key_o;
  logic        deregister_key_o;

  chained_hash_key_value_table i_dut (.*);

  table_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  logic [63:0] key_pool[KeyPoolSize];

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stall, with a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left == 0 && hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = 800;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall_i = 1;
    end else begin
      stall_i = $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(posedge clk_i) begin
    table_result_t got;
    if (rst_ni && valid_o && !stall_i) begin
      got.status = status_e'(status_o);
      got.present = present_o;
      got.out_value = out_value_o;
      got.retain_out = retain_out_o;
      got.retain_input = retain_input_o;
      got.release_value = release_value_o;
      got.release_valid = release_valid_o;
      got.register_key = register_key_o;
      got.deregister_key = deregister_key_o;
      sb.check_result(got);
    end
  end

  task automatic send_item(logic [2:0] func, logic [63:0] key, logic [63:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      valid_i = 0;
      @(negedge clk_i);
    end
    valid_i = 1;
    func_i = func;
    key_i = key;
    value_i = value;
    do @(posedge clk_i); while (stall_o);
    sb.note_item(func, key, value);
    @(negedge clk_i);
    valid_i = 0;
  endtask

  task automatic drain();
    valid_i = 0;
    while (sb.awaited.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic random_items(int unsigned n);
    int unsigned pick;
    logic [63:0] k;
    logic [63:0] v;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      k = key_pool[$urandom_range(KeyPoolSize - 1)];
      v = ($urandom_range(9) == 0) ? 64'd0 : rand64();
      if (pick < 40) send_item(FuncSet, k, v);
      else if (pick < 60) send_item(FuncGet, k, v);
      else if (pick < 70) send_item(FuncHas, k, v);
      else if (pick < 83) send_item(FuncDel, k, v);
      else if (pick < 95) send_item(FuncInval, k, v);
      else if (pick < 97) send_item(3'($urandom_range(7)), 64'd0, v);
      else send_item(3'($urandom_range(7, 5)), k, v);
    end
  endtask

  initial begin
    for (int i = 0; i < KeyPoolSize; i++) begin
      key_pool[i] = rand64();
      if (key_pool[i] == 0) key_pool[i] = 64'(i + 1);
    end
    key_pool[0] = '1;
    key_pool[1] = 64'd1;
    repeat (7) @(negedge clk_i);
    rst_ni = 1;

    for (int f = 0; f < 8; f++) send_item(3'(f), 64'd0, '1);
    for (int f = 5; f < 8; f++) send_item(3'(f), key_pool[0], '1);
    send_item(FuncGet, key_pool[0], 0);
    send_item(FuncHas, key_pool[0], 0);
    send_item(FuncDel, key_pool[0], 0);
    send_item(FuncInval, key_pool[0], 0);
    send_item(FuncSet, key_pool[0], '1);
    send_item(FuncSet, key_pool[1], 64'd0);
    send_item(FuncGet, key_pool[1], 0);
    send_item(FuncSet, key_pool[0], 64'h8000_0000_0000_0001);
    send_item(FuncGet, key_pool[0], 0);
    send_item(FuncHas, key_pool[0], 0);
    send_item(FuncDel, key_pool[0], 0);
    send_item(FuncSet, key_pool[1], '1);
    send_item(FuncInval, key_pool[1], 0);
    send_item(FuncGet, key_pool[1], 0);
    drain();

    // fill the pool past full with the receiver held off
    hold_requests++;
    for (int i = 0; i < 200; i++) send_item(FuncSet, key_pool[i], rand64());
    send_item(FuncSet, key_pool[5], 64'd0);
    for (int i = 0; i < 200; i += 2) send_item(FuncDel, key_pool[i], 0);
    drain();

    random_items(350);
    drain();
    send_idle_pct = 77;
    random_items(350);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 77;
    random_items(350);
    drain();
    send_idle_pct = 17;
    recv_stall_pct = 17;
    random_items(350);
    drain();

    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
